// File: rtl/core/rwl_pkg.sv
package rwl_pkg;

   typedef enum logic [2:0] {
      CMD_TRY_READ      = 3'd0,
      CMD_READ_UNLOCK   = 3'd1,
      CMD_TRY_UPGRADE   = 3'd2,
      CMD_TRY_WRITE     = 3'd3,
      CMD_WRITE_ATTEMPT = 3'd4,
      CMD_WRITE_UNLOCK  = 3'd5,
      CMD_DOWNGRADE     = 3'd6,
      CMD_QUERY         = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_REFUSED = 2'd1,
      ST_MISUSE  = 2'd2
   } status_type;

   localparam int CMD_W       = 3;
   localparam int REQUESTER_W = 8;
   localparam int READERS_W   = 16;
   localparam int DEPTH_W     = 8;

   // result word, last field in the lowest bits
   typedef struct packed {
      logic [1:0]           pad;
      logic [DEPTH_W-1:0]   depth_now;
      logic                 any_holders;
      logic                 owned_by_requester;
      logic                 writer_waiting;
      logic                 held_for_write;
      logic [READERS_W-1:0] readers_now;
      status_type           status;
   } rsp_type;

endpackage

// File: rtl/core/rwl_core.sv
module rwl_core import rwl_pkg::*; #(
   parameter int READER_BITS = 16,
   parameter int ID_BITS     = 8,
   parameter int DEPTH_BITS  = 8
) (
   input  cmd_type                 command,
   input  logic [REQUESTER_W-1:0]  requester,
   input  logic [READER_BITS-1:0]  reader_count,
   input  logic                    write_held,
   input  logic                    write_pending,
   input  logic                    owner_valid,
   input  logic [ID_BITS-1:0]      owner_id,
   input  logic [DEPTH_BITS-1:0]   depth,
   output logic [READER_BITS-1:0]  reader_count_in,
   output logic                    write_held_in,
   output logic                    write_pending_in,
   output logic                    owner_valid_in,
   output logic [ID_BITS-1:0]      owner_id_in,
   output logic [DEPTH_BITS-1:0]   depth_in,
   output rsp_type                 rsp
);

   logic [ID_BITS+REQUESTER_W-1:0]  who_ext;
   logic [ID_BITS-1:0]              who;
   logic [READER_BITS+READERS_W-1:0] readers_ext;
   logic [DEPTH_BITS+DEPTH_W-1:0]   depth_ext;
   logic                            is_owner;
   logic                            owner_check;
   logic                            write_free;
   logic                            write_ok;
   status_type                      write_status;
   status_type                      status;

   // requester id is taken in its low ID_BITS bits
   assign who_ext = {{ID_BITS{1'b0}}, requester};
   assign who     = who_ext[ID_BITS-1:0];

   assign is_owner    = owner_valid && (owner_id == who);
   assign owner_check = is_owner && (write_held || write_pending);
   assign write_free  = (reader_count == '0) && !write_held;
   // recursive grant by the owner, refused once depth is saturated
   assign write_ok    = write_free || (write_held && is_owner && !(&depth));
   assign write_status = write_ok ? ST_OK : ST_REFUSED;

   always_comb begin
      reader_count_in  = reader_count;
      write_held_in    = write_held;
      write_pending_in = write_pending;
      owner_valid_in   = owner_valid;
      owner_id_in      = owner_id;
      depth_in         = depth;
      status           = ST_OK;
      case (command)
         CMD_TRY_READ: begin
            if (!write_held && !write_pending && !(&reader_count)) begin
               reader_count_in = reader_count + 1'b1;
            end else begin
               status = ST_REFUSED;
            end
         end
         CMD_READ_UNLOCK: begin
            if (owner_valid || write_held || reader_count == '0) begin
               status = ST_MISUSE;
            end else begin
               reader_count_in = reader_count - 1'b1;
            end
         end
         CMD_TRY_UPGRADE: begin
            if (reader_count == READER_BITS'(1) && !write_held && !write_pending) begin
               reader_count_in  = '0;
               write_held_in    = 1'b1;
               write_pending_in = 1'b1;
               owner_valid_in   = 1'b1;
               owner_id_in      = who;
               depth_in         = '0;
            end else begin
               status = ST_REFUSED;
            end
         end
         CMD_TRY_WRITE, CMD_WRITE_ATTEMPT: begin
            status = write_status;
            if (write_free) begin
               write_held_in    = 1'b1;
               write_pending_in = 1'b1;
               owner_valid_in   = 1'b1;
               owner_id_in      = who;
               depth_in         = '0;
            end else if (write_ok) begin
               depth_in = depth + 1'b1;
            end else if (command == CMD_WRITE_ATTEMPT) begin
               // failed blocking pass shuts out new readers
               write_pending_in = 1'b1;
            end
         end
         CMD_WRITE_UNLOCK: begin
            if (!owner_check) begin
               status = ST_MISUSE;
            end else if (depth != '0) begin
               depth_in = depth - 1'b1;
            end else begin
               owner_valid_in   = 1'b0;
               owner_id_in      = '0;
               write_held_in    = 1'b0;
               write_pending_in = 1'b0;
            end
         end
         CMD_DOWNGRADE: begin
            if (!owner_check) begin
               status = ST_MISUSE;
            end else begin
               depth_in         = '0;
               write_held_in    = 1'b0;
               write_pending_in = 1'b0;
               owner_valid_in   = 1'b0;
               owner_id_in      = '0;
               if (!(&reader_count)) begin
                  reader_count_in = reader_count + 1'b1;
               end
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   assign readers_ext = {{READERS_W{1'b0}}, reader_count_in};
   assign depth_ext   = {{DEPTH_W{1'b0}}, depth_in};

   always_comb begin
      rsp.pad                = '0;
      rsp.status             = status;
      rsp.readers_now        = readers_ext[READERS_W-1:0];
      rsp.held_for_write     = write_held_in;
      rsp.writer_waiting     = write_pending_in;
      rsp.owned_by_requester = owner_valid_in && (owner_id_in == who);
      rsp.any_holders        = (reader_count_in != '0) || write_held_in || write_pending_in;
      rsp.depth_now          = depth_ext[DEPTH_W-1:0];
   end

endmodule

// File: rtl/core/reader_writer_lock_unit.sv
// Reader-writer lock served over a request stream.
//
// req_* carries one request word per transfer: a command (try read, read
// unlock, try upgrade, try write, write attempt, write unlock, downgrade,
// query) and the requester id. rsp_* returns exactly one result word per
// request, in order: status, reader count, write-held, write-pending,
// ownership by the requester, any-holders and the writer recursion depth.
//
// A request waits in the input register; the lock state update and the result
// are computed combinationally from it and land in the result register, from
// which the result is offered. One request per cycle is sustained while rsp_tready
// stays high; the limit is the single read-modify-write of the lock state.
//
// Reset leaves the lock free (no readers, no owner, depth zero) and both
// channels empty. When rsp_tready is low the result register holds, the
// input register keeps its word and req_tready drops only once both are full.
module reader_writer_lock_unit import rwl_pkg::*; #(
   parameter int READER_BITS = 16,
   parameter int ID_BITS     = 8,
   parameter int DEPTH_BITS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // command[2:0], requester[10:3], zero[15:11]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // status[1:0], readers_now[17:2], held_for_write[18],
                                    // writer_waiting[19], owned_by_requester[20],
                                    // any_holders[21], depth_now[29:22], zero[31:30]
);

   logic                         in_valid_ff;
   logic [CMD_W-1:0]             in_cmd_ff;
   logic [REQUESTER_W-1:0]       in_who_ff;
   logic                         out_valid_ff;
   rsp_type                      out_ff;

   logic [READER_BITS-1:0]       reader_count_ff, reader_count_in;
   logic                         write_held_ff, write_held_in;
   logic                         write_pending_ff, write_pending_in;
   logic                         owner_valid_ff, owner_valid_in;
   logic [ID_BITS-1:0]           owner_id_ff, owner_id_in;
   logic [DEPTH_BITS-1:0]        depth_ff, depth_in;
   rsp_type                      rsp_in;

   logic                         out_free;
   logic                         advance;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   rwl_core #(
      .READER_BITS (READER_BITS),
      .ID_BITS     (ID_BITS),
      .DEPTH_BITS  (DEPTH_BITS)
   ) u_core (
      .command          (cmd_type'(in_cmd_ff)),
      .requester        (in_who_ff),
      .reader_count     (reader_count_ff),
      .write_held       (write_held_ff),
      .write_pending    (write_pending_ff),
      .owner_valid      (owner_valid_ff),
      .owner_id         (owner_id_ff),
      .depth            (depth_ff),
      .reader_count_in  (reader_count_in),
      .write_held_in    (write_held_in),
      .write_pending_in (write_pending_in),
      .owner_valid_in   (owner_valid_in),
      .owner_id_in      (owner_id_in),
      .depth_in         (depth_in),
      .rsp              (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         reader_count_ff  <= '0;
         write_held_ff    <= 1'b0;
         write_pending_ff <= 1'b0;
         owner_valid_ff   <= 1'b0;
         owner_id_ff      <= '0;
         depth_ff         <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            reader_count_ff  <= reader_count_in;
            write_held_ff    <= write_held_in;
            write_pending_ff <= write_pending_in;
            owner_valid_ff   <= owner_valid_in;
            owner_id_ff      <= owner_id_in;
            depth_ff         <= depth_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff <= req_tdata[CMD_W-1:0];
         in_who_ff <= req_tdata[CMD_W+REQUESTER_W-1:CMD_W];
      end
      if (advance) begin
         out_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import rwl_pkg::*;

   localparam int QUIET_LIMIT  = 1000;
   localparam int HOLD_CYCLES  = 80;
   localparam int TAIL_CYCLES  = 8;
   localparam int REPORT_LINES = 40;

   localparam logic [READERS_W-1:0] READERS_FULL = '1;
   localparam logic [DEPTH_W-1:0]   DEPTH_FULL   = '1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // command[2:0], requester[10:3], zero[15:11]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // status[1:0], readers_now[17:2], held_for_write[18],
                                  // writer_waiting[19], owned_by_requester[20],
                                  // any_holders[21], depth_now[29:22], zero[31:30]

   reader_writer_lock_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // request words waiting for the driver, and lock results still owed by the block
   logic [15:0] requests_to_send[$];
   rsp_type     lock_results_due[$];
   int          words_queued = 0;
   int          mismatch_count = 0;
   int          quiet_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic        hold_request = 1'b0;
   logic        hold_done = 1'b0;
   int          hold_left = 0;

   // predicted lock state
   logic [READERS_W-1:0]   lk_readers = '0;
   logic                   lk_held = 1'b0;
   logic                   lk_pending = 1'b0;
   logic                   lk_owned = 1'b0;
   logic [REQUESTER_W-1:0] lk_owner = '0;
   logic [DEPTH_W-1:0]     lk_depth = '0;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic logic is_owner(logic [REQUESTER_W-1:0] who);
      return lk_owned && lk_owner == who;
   endfunction

   function automatic void seize_write(logic [REQUESTER_W-1:0] who);
      lk_held    = 1'b1;
      lk_pending = 1'b1;
      lk_owned   = 1'b1;
      lk_owner   = who;
      lk_depth   = '0;
   endfunction

   function automatic void drop_write();
      lk_held    = 1'b0;
      lk_pending = 1'b0;
      lk_owned   = 1'b0;
      lk_owner   = '0;
      lk_depth   = '0;
   endfunction

   function automatic status_type write_grant(logic [REQUESTER_W-1:0] who);
      if (lk_readers == '0 && !lk_held) begin
         seize_write(who);
         return ST_OK;
      end
      if (lk_held && is_owner(who) && lk_depth != DEPTH_FULL) begin
         lk_depth++;
         return ST_OK;
      end
      return ST_REFUSED;
   endfunction

   function automatic rsp_type predict_lock_result(cmd_type cmd, logic [REQUESTER_W-1:0] who);
      rsp_type    r;
      status_type st;
      st = ST_OK;
      case (cmd)
         CMD_TRY_READ: begin
            if (!lk_held && !lk_pending && lk_readers != READERS_FULL) lk_readers++;
            else st = ST_REFUSED;
         end
         CMD_READ_UNLOCK: begin
            if (lk_owned || lk_held || lk_readers == '0) st = ST_MISUSE;
            else lk_readers--;
         end
         CMD_TRY_UPGRADE: begin
            if (lk_readers == 1 && !lk_held && !lk_pending) begin
               lk_readers = '0;
               seize_write(who);
            end else begin
               st = ST_REFUSED;
            end
         end
         CMD_TRY_WRITE: st = write_grant(who);
         CMD_WRITE_ATTEMPT: begin
            st = write_grant(who);
            if (st != ST_OK) lk_pending = 1'b1;
         end
         CMD_WRITE_UNLOCK: begin
            if (!(is_owner(who) && (lk_held || lk_pending))) st = ST_MISUSE;
            else if (lk_depth != '0) lk_depth--;
            else drop_write();
         end
         CMD_DOWNGRADE: begin
            if (!(is_owner(who) && (lk_held || lk_pending))) begin
               st = ST_MISUSE;
            end else begin
               drop_write();
               if (lk_readers != READERS_FULL) lk_readers++;
            end
         end
         default: ;
      endcase
      r.pad                = '0;
      r.status             = st;
      r.readers_now        = lk_readers;
      r.held_for_write     = lk_held;
      r.writer_waiting     = lk_pending;
      r.owned_by_requester = is_owner(who);
      r.any_holders        = lk_readers != '0 || lk_held || lk_pending;
      r.depth_now          = lk_depth;
      return r;
   endfunction

   // driver: presents the next word once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready)
            lock_results_due.push_back(
               predict_lock_result(cmd_type'(req_tdata[2:0]), req_tdata[10:3]));
         if (!req_tvalid || req_tready) begin
            if (requests_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= requests_to_send.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_request && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || hold_left != 0) rsp_tready <= 1'b0;
      else rsp_tready <= $urandom_range(0, 99) >= recv_stall_pct;
   end

   task automatic report_mismatch(string field, logic [31:0] got_v, logic [31:0] want_v);
      mismatch_count++;
      if (mismatch_count <= REPORT_LINES)
         $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, field, got_v,
                  want_v);
   endtask

   // monitor
   always @(posedge clock) begin : check_results
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (lock_results_due.size() == 0) begin
            report_mismatch("unexpected word", got, '0);
         end else begin
            want = lock_results_due.pop_front();
            if (got.status != want.status)
               report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.readers_now != want.readers_now)
               report_mismatch("readers_now", 32'(got.readers_now), 32'(want.readers_now));
            if (got.held_for_write != want.held_for_write)
               report_mismatch("held_for_write", 32'(got.held_for_write),
                               32'(want.held_for_write));
            if (got.writer_waiting != want.writer_waiting)
               report_mismatch("writer_waiting", 32'(got.writer_waiting),
                               32'(want.writer_waiting));
            if (got.owned_by_requester != want.owned_by_requester)
               report_mismatch("owned_by_requester", 32'(got.owned_by_requester),
                               32'(want.owned_by_requester));
            if (got.any_holders != want.any_holders)
               report_mismatch("any_holders", 32'(got.any_holders), 32'(want.any_holders));
            if (got.depth_now != want.depth_now)
               report_mismatch("depth_now", 32'(got.depth_now), 32'(want.depth_now));
            if (got.pad != '0)
               report_mismatch("pad", 32'(got.pad), '0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_request(cmd_type cmd, logic [REQUESTER_W-1:0] who);
      requests_to_send.push_back({5'b0, who, cmd});
      words_queued++;
   endtask

   // mostly a few ids so that ownership matches happen
   function automatic logic [REQUESTER_W-1:0] pick_requester();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h5A;
         3: return 8'hA5;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic queue_random_traffic(int count);
      int                     stop_at;
      int                     kind;
      int                     depth;
      logic [REQUESTER_W-1:0] who;
      stop_at = words_queued + count;
      while (words_queued < stop_at) begin
         kind = $urandom_range(0, 99);
         who  = pick_requester();
         if (kind < 35) begin
            queue_request(CMD_TRY_READ, who);
            if ($urandom_range(0, 3) == 0) begin
               queue_request(CMD_TRY_UPGRADE, who);
               queue_request(CMD_WRITE_UNLOCK, who);
            end else if ($urandom_range(0, 2) == 0) begin
               queue_request(CMD_QUERY, who);
            end
            queue_request(CMD_READ_UNLOCK, who);
         end else if (kind < 75) begin
            queue_request($urandom_range(0, 1) ? CMD_TRY_WRITE : CMD_WRITE_ATTEMPT, who);
            depth = $urandom_range(0, 3);
            repeat (depth) queue_request(CMD_TRY_WRITE, who);
            if ($urandom_range(0, 2) == 0) queue_request(CMD_QUERY, who);
            if ($urandom_range(0, 3) == 0) begin
               queue_request(CMD_DOWNGRADE, who);
               queue_request(CMD_READ_UNLOCK, who);
            end else begin
               repeat (depth + 1) queue_request(CMD_WRITE_UNLOCK, who);
            end
         end else begin
            queue_request(cmd_type'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
         end
      end
   endtask

   // stimulus side waits at the falling edge, away from the sampling edge
   task automatic wait_drained();
      @(negedge clock);
      while (requests_to_send.size() != 0 || req_tvalid || lock_results_due.size() != 0)
         @(negedge clock);
   endtask

   // bring the lock back to free, working from the predicted state
   task automatic queue_lock_cleanup();
      if (lk_owned) begin
         repeat (int'(lk_depth) + 1) queue_request(CMD_WRITE_UNLOCK, lk_owner);
      end else begin
         repeat (int'(lk_readers)) queue_request(CMD_READ_UNLOCK, 8'h00);
         if (lk_pending) begin
            queue_request(CMD_TRY_WRITE, 8'h00);
            queue_request(CMD_WRITE_UNLOCK, 8'h00);
         end
      end
   endtask

   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);

      // directed walk through every command and the misuse cases
      queue_request(CMD_QUERY, 8'h00);
      queue_request(CMD_READ_UNLOCK, 8'hFF);       // no readers
      queue_request(CMD_WRITE_UNLOCK, 8'h00);      // no owner
      queue_request(CMD_DOWNGRADE, 8'h55);
      queue_request(CMD_TRY_READ, 8'hAA);
      queue_request(CMD_TRY_READ, 8'h55);
      queue_request(CMD_TRY_UPGRADE, 8'hAA);       // two readers, refused
      queue_request(CMD_READ_UNLOCK, 8'h55);
      queue_request(CMD_TRY_UPGRADE, 8'hFF);       // one reader left, requester becomes owner
      queue_request(CMD_TRY_WRITE, 8'h00);
      queue_request(CMD_WRITE_ATTEMPT, 8'h00);
      queue_request(CMD_TRY_WRITE, 8'hFF);         // recursion
      queue_request(CMD_READ_UNLOCK, 8'h55);       // owner present
      queue_request(CMD_WRITE_UNLOCK, 8'h00);      // not the owner
      queue_request(CMD_WRITE_UNLOCK, 8'hFF);
      queue_request(CMD_DOWNGRADE, 8'hFF);
      queue_request(CMD_TRY_READ, 8'h00);
      queue_request(CMD_WRITE_ATTEMPT, 8'h55);     // pending without owner
      queue_request(CMD_TRY_READ, 8'hAA);          // shut out by pending
      queue_request(CMD_READ_UNLOCK, 8'h00);
      queue_request(CMD_READ_UNLOCK, 8'hFF);
      queue_request(CMD_TRY_WRITE, 8'h00);         // granted despite pending
      queue_request(CMD_QUERY, 8'h00);
      queue_request(CMD_WRITE_UNLOCK, 8'h00);
      queue_request(CMD_WRITE_ATTEMPT, 8'hAA);
      queue_request(CMD_WRITE_UNLOCK, 8'hAA);
      wait_drained();

      queue_random_traffic(90);
      wait_drained();

      send_idle_pct = 49;
      queue_random_traffic(90);
      wait_drained();

      // long receiver hold while the sender keeps offering
      send_idle_pct = 0;
      queue_random_traffic(50);
      hold_request = 1'b1;
      wait_drained();

      recv_stall_pct = 49;
      queue_random_traffic(90);
      wait_drained();

      send_idle_pct  = 8;
      recv_stall_pct = 8;
      queue_random_traffic(90);
      wait_drained();
      queue_lock_cleanup();
      wait_drained();

      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && lock_results_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: reader_writer_lock_unit.f
rtl/core/rwl_pkg.sv
rtl/core/rwl_core.sv
rtl/core/reader_writer_lock_unit.sv
sim/testbench.sv
